FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: word layouts,
// operation and register codes, cell constants and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int CELL_INDEX_W = 11;
    localparam int CELL_DATA_W  = 16;
    localparam int CUR_ROW_W    = 5;
    localparam int CUR_COL_W    = 7;
    localparam int CUR_POS_W    = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 2'd1;

    localparam logic [7:0]             NEWLINE_CODE = 8'd10;
    localparam logic [CELL_DATA_W-1:0] BLANK_CELL   = 16'h0720;
    localparam logic [CFG_DATA_W-1:0]  FG_RESET     = 4'd7;
    localparam logic [CFG_DATA_W-1:0]  BG_RESET     = 4'd0;

    typedef struct packed {
        logic                    op;
        logic [7:0]              char_code;
        logic [CELL_INDEX_W-1:0] cell_index;
    } in_word_t;

    typedef struct packed {
        logic [CELL_DATA_W-1:0] cell_data;
        logic [CUR_ROW_W-1:0]   cursor_row;
        logic [CUR_COL_W-1:0]   cursor_col;
        logic [CUR_POS_W-1:0]   cursor_position;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: a ROWS x COLS screen of attribute/character cells and
// a cursor, written by put words and read back for display refresh.
// ----------------------------------------------------------------------------
// Usage
//   in channel  : in_valid / in_stall / in_word (op, char_code, cell_index)
//   out channel : out_valid / out_stall / out_word, one word per input word
//   config      : cfg_wr_en / cfg_index / cfg_data sets the fg and bg nibbles
// Timing
//   after reset a clearing pass writes the blank cell to every screen entry,
//   one cell a cycle; in_stall is high throughout the pass
//   put of a character or a newline without scroll: result registered at the
//   accepting edge, next word accepted the following cycle unless the output stalls
//   read: the cell comes through the registered read port of the screen memory
//   newline on the bottom row: the scroll sweep moves one cell per cycle
//   through the single memory port pair, then ST_FINISH sends the result word
//   one word is in work at a time
// Stall
//   the result sits in an output register; a new word is taken only once
//   that register is empty or being drained in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  tcw_pkg::in_word_t                  in_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output tcw_pkg::out_word_t                 out_word,
    input  logic                               cfg_wr_en,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = AW + 1;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int IW    = (AW > CELL_INDEX_W) ? AW : CELL_INDEX_W;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [RW-1:0]          row_reg, row_next;
    logic [CW-1:0]          col_reg, col_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [CFG_DATA_W-1:0]  fg_reg, bg_reg;
    logic                   wb_valid_reg, wb_valid_next;
    logic [AW-1:0]          wb_addr_reg, wb_addr_next;
    logic                   wb_blank_reg, wb_blank_next;
    logic                   hit_reg, hit_next;
    logic                   out_valid_reg, out_valid_next;
    out_word_t              out_word_reg, out_word_next;

    logic                   we, re;
    logic [AW-1:0]          wa, ra;
    logic [CELL_DATA_W-1:0] wd, rd_data;

    logic                   in_accept, out_free, is_read, is_nl, in_range;
    logic                   last_row, last_col, src_blank;
    logic [IW-1:0]          cell_ext;
    logic [SW-1:0]          src;

    function automatic out_word_t pack_out(
        input logic [CELL_DATA_W-1:0] data,
        input logic [RW-1:0]          r,
        input logic [CW-1:0]          c,
        input logic [AW-1:0]          p
    );
        out_word_t w;
        w.cell_data       = data;
        w.cursor_row      = CUR_ROW_W'(r);
        w.cursor_col      = CUR_COL_W'(c);
        w.cursor_position = CUR_POS_W'(p);
        return w;
    endfunction

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (CELL_DATA_W)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .wa      (wa),
        .wd      (wd),
        .re      (re),
        .ra      (ra),
        .rd_data (rd_data)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;
    assign is_read   = (in_word.op == OP_READ);
    assign is_nl     = (in_word.char_code == NEWLINE_CODE);
    assign cell_ext  = IW'(in_word.cell_index);
    assign in_range  = (cell_ext < IW'(CELLS));
    assign last_row  = (row_reg == RW'(ROWS - 1));
    assign last_col  = (col_reg == CW'(COLS - 1));
    // scroll source is one row below the cell being rewritten
    assign src       = {1'b0, idx_reg} + SW'(COLS);
    assign src_blank = (idx_reg >= AW'(CELLS - COLS));

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        pos_next       = pos_reg;
        wb_valid_next  = 1'b0;
        wb_addr_next   = wb_addr_reg;
        wb_blank_next  = wb_blank_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        re             = 1'b0;
        ra             = idx_reg;
        we             = 1'b0;
        wa             = wb_addr_reg;
        wd             = BLANK_CELL;

        // pending scroll write-back of the cell read last cycle
        if (wb_valid_reg)
        begin
            we = 1'b1;
            wa = wb_addr_reg;
            wd = wb_blank_reg ? BLANK_CELL : rd_data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                wa       = idx_reg;
                wd       = BLANK_CELL;
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(CELLS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    priority if (is_read)
                    begin
                        re         = in_range;
                        ra         = cell_ext[AW-1:0];
                        hit_next   = in_range;
                        state_next = ST_READ;
                    end
                    else if (is_nl)
                    begin
                        col_next = '0;
                        if (last_row)
                        begin
                            pos_next   = pos_reg - AW'(col_reg);
                            idx_next   = '0;
                            state_next = ST_SCROLL;
                        end
                        else
                        begin
                            row_next       = row_reg + RW'(1);
                            pos_next       = pos_reg - AW'(col_reg) + AW'(COLS);
                            out_valid_next = 1'b1;
                            out_word_next  = pack_out('0, row_next, col_next, pos_next);
                        end
                    end
                    else
                    begin
                        we = 1'b1;
                        wa = pos_reg;
                        wd = {bg_reg, fg_reg, in_word.char_code};
                        if (last_col)
                        begin
                            col_next = '0;
                            if (last_row)
                            begin
                                row_next = '0;
                                pos_next = '0;
                            end
                            else
                            begin
                                row_next = row_reg + RW'(1);
                                pos_next = pos_reg + AW'(1);
                            end
                        end
                        else
                        begin
                            col_next = col_reg + CW'(1);
                            pos_next = pos_reg + AW'(1);
                        end
                        out_valid_next = 1'b1;
                        out_word_next  = pack_out({bg_reg, fg_reg, in_word.char_code},
                                                  row_next, col_next, pos_next);
                    end
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = pack_out(hit_reg ? rd_data : '0,
                                              row_reg, col_reg, pos_reg);
                    state_next     = ST_IDLE;
                end
            end
            ST_SCROLL:
            begin
                re            = !src_blank;
                ra            = src[AW-1:0];
                wb_valid_next = 1'b1;
                wb_addr_next  = idx_reg;
                wb_blank_next = src_blank;
                idx_next      = idx_reg + AW'(1);
                if (idx_reg == AW'(CELLS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = pack_out('0, row_reg, col_reg, pos_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            pos_reg       <= '0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fg_reg        <= FG_RESET;
            bg_reg        <= BG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            pos_reg       <= pos_next;
            wb_valid_reg  <= wb_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_FG_COLOR)
                begin
                    fg_reg <= cfg_data;
                end
                else if (cfg_index == REG_BG_COLOR)
                begin
                    bg_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wb_addr_reg  <= wb_addr_next;
        wb_blank_reg <= wb_blank_next;
        hit_reg      <= hit_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

FILE: rtl/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell memory: one write port and one read port with registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] wa,
    input  logic [DW-1:0] wd,
    input  logic          re,
    input  logic [AW-1:0] ra,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_data_reg <= mem[ra];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_console_writer. Put, newline and read words
// are pushed through the valid/stall input with random bursts and gaps. A
// local screen and cursor model predicts each output word, and the output
// side stalls on a changing pattern, with one long hold to back up the input.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLS        = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLS * ROWS;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 330;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_word;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_word;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // console model
    logic [15:0]           screen_m [0:CELLS-1];
    int                    cur_row_m;
    int                    cur_col_m;
    logic [3:0]            fg_m;
    logic [3:0]            bg_m;
    out_word_t             cell_cursor_q [$];

    int fail_count;
    int words_sent;
    int reads_sent;
    int newlines_sent;
    int scroll_count;
    int scroll_limit;
    int reg_writes;
    int burst_left;
    bit hold_req;

    text_console_writer #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // advance the model by one accepted word and return the word it produces
    function automatic out_word_t apply_console_word(input in_word_t w);
        out_word_t   r;
        logic [15:0] data;
        int          pos;
        data = '0;
        if (w.op == OP_READ)
        begin
            reads_sent++;
            if (w.cell_index < CELLS)
                data = screen_m[w.cell_index];
        end
        else if (w.char_code == NEWLINE_CODE)
        begin
            newlines_sent++;
            cur_col_m = 0;
            cur_row_m++;
            if (cur_row_m >= ROWS)
            begin
                for (int i = 0; i < CELLS - COLS; i++)
                    screen_m[i] = screen_m[i + COLS];
                for (int i = CELLS - COLS; i < CELLS; i++)
                    screen_m[i] = BLANK_CELL;
                cur_row_m = ROWS - 1;
                scroll_count++;
            end
        end
        else
        begin
            data = {bg_m, fg_m, w.char_code};
            pos = cur_row_m * COLS + cur_col_m;
            screen_m[pos] = data;
            cur_col_m++;
            if (cur_col_m >= COLS)
            begin
                cur_col_m = 0;
                cur_row_m++;
                if (cur_row_m >= ROWS)
                    cur_row_m = 0;
            end
        end
        r.cell_data       = data;
        r.cursor_row      = cur_row_m[CUR_ROW_W-1:0];
        r.cursor_col      = cur_col_m[CUR_COL_W-1:0];
        r.cursor_position = CUR_POS_W'(cur_row_m * COLS + cur_col_m);
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cell_cursor_q.size() == 0)
            begin
                $error("output word 0x%0h with nothing pending", out_word);
                fail_count++;
            end
            else
            begin
                want = cell_cursor_q.pop_front();
                check_field("cell_data", int'(want.cell_data), int'(out_word.cell_data));
                check_field("cursor_row", int'(want.cursor_row),
                            int'(out_word.cursor_row));
                check_field("cursor_col", int'(want.cursor_col),
                            int'(out_word.cursor_col));
                check_field("cursor_position", int'(want.cursor_position),
                            int'(out_word.cursor_position));
            end
        end
    end

    // output stall pattern, with a long hold on request
    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        int          hold_left;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // offer one word, in bursts with random gaps, and wait for it to be taken
    task automatic send_word(input in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
        cell_cursor_q.push_back(apply_console_word(w));
        words_sent++;
        burst_left--;
    endtask

    task automatic put_char(input logic [7:0] c);
        in_word_t w;
        w.op         = OP_PUT;
        w.char_code  = c;
        w.cell_index = CELL_INDEX_W'($urandom_range(0, 2047));
        send_word(w);
    endtask

    task automatic read_cell(input int idx);
        in_word_t w;
        w.op         = OP_READ;
        w.char_code  = 8'($urandom_range(0, 255));
        w.cell_index = CELL_INDEX_W'(idx);
        send_word(w);
    endtask

    function automatic logic [7:0] random_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == NEWLINE_CODE);
        return c;
    endfunction

    // keep the slow scroll sweeps to a bounded number per phase
    function automatic bit newline_ok();
        if (cur_row_m != ROWS - 1)
            return 1'b1;
        return scroll_count < scroll_limit && $urandom_range(0, 3) == 0;
    endfunction

    task automatic read_somewhere();
        int r;
        int pos;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            pos = cur_row_m * COLS + cur_col_m - $urandom_range(0, 160);
            read_cell(pos < 0 ? 0 : pos);
        end
        else if (r < 85)
            read_cell($urandom_range(0, CELLS - 1));
        else
            read_cell($urandom_range(CELLS, 2047));
    endtask

    // drop in_valid and wait until the block has drained
    task automatic settle();
        in_valid <= 1'b0;
        while (cell_cursor_q.size() != 0 || in_stall)
            @(posedge clk);
        repeat (4) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_FG_COLOR)
            fg_m = val;
        else if (idx == REG_BG_COLOR)
            bg_m = val;
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic test_directed();
        read_cell(0);
        read_cell(CELLS - 1);
        read_cell(CELLS);
        read_cell(2047);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(NEWLINE_CODE);
        read_cell(0);
        read_cell(2);
        read_cell(COLS);
        put_char(NEWLINE_CODE - 8'd1);
        put_char(NEWLINE_CODE + 8'd1);
        read_cell(COLS + 1);
    endtask

    // walk down to the bottom row and scroll twice
    task automatic test_scroll();
        while (cur_row_m < ROWS - 1)
            put_char(NEWLINE_CODE);
        put_char(random_char());
        read_cell(CELLS - COLS);
        put_char(NEWLINE_CODE);
        read_cell(CELLS - 2 * COLS);
        read_cell(CELLS - COLS);
        put_char(NEWLINE_CODE);
        read_cell(CELLS - 3 * COLS);
        read_cell(0);
    endtask

    // a full line on the bottom row wraps to the top, then one more line
    task automatic test_wrap();
        repeat (2 * COLS)
            put_char(random_char());
        read_cell(CELLS - COLS);
        read_cell(CELLS - 1);
        read_cell(0);
        read_cell(COLS - 1);
    endtask

    task automatic test_colors();
        settle();
        write_reg(REG_FG_COLOR, 4'hF);
        write_reg(REG_BG_COLOR, 4'hF);
        put_char(8'h55);
        put_char(8'hAA);
        read_somewhere();
        settle();
        write_reg(REG_FG_COLOR, 4'h0);
        write_reg(REG_BG_COLOR, 4'h0);
        put_char(8'h33);
        put_char(8'hCC);
        settle();
        write_reg(REG_SPARE_2, 4'hA);
        write_reg(REG_SPARE_3, 4'h5);
        put_char(8'h7E);
        read_cell(cur_row_m * COLS + (cur_col_m == 0 ? 0 : cur_col_m - 1));
    endtask

    task automatic test_backpressure();
        settle();
        hold_req = 1'b1;
        repeat (12)
        begin
            if ($urandom_range(0, 1) == 0)
                put_char(random_char());
            else
                read_somewhere();
        end
    endtask

    // lines of text of random length, ending in newline unless the scroll limit or a
    // random draw bars it on the bottom row, reads mixed in, and a share of unstructured words
    task automatic test_random_text(input int n_items);
        int         stop_at;
        int         len;
        in_word_t   w;
        stop_at      = words_sent + n_items;
        scroll_limit = scroll_count + 10;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                len = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 30)
                                                 : $urandom_range(60, 100);
                repeat (len)
                begin
                    if ($urandom_range(0, 5) == 0)
                        read_somewhere();
                    put_char(random_char());
                end
                if (newline_ok())
                    put_char(NEWLINE_CODE);
            end
            else
            begin
                repeat (6)
                begin
                    w.op         = 1'($urandom_range(0, 1));
                    w.char_code  = ($urandom_range(0, 7) == 0) ? NEWLINE_CODE
                                                               : 8'($urandom_range(0, 255));
                    w.cell_index = CELL_INDEX_W'($urandom_range(0, 2047));
                    if (w.op == OP_PUT && w.char_code == NEWLINE_CODE && !newline_ok())
                        w.char_code = random_char();
                    send_word(w);
                end
            end
        end
    endtask

    initial
    begin
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        hold_req   = 1'b0;
        fail_count = 0;
        words_sent = 0;
        reads_sent = 0;
        newlines_sent = 0;
        scroll_count  = 0;
        scroll_limit  = 0;
        reg_writes    = 0;
        burst_left    = 0;
        for (int i = 0; i < CELLS; i++)
            screen_m[i] = BLANK_CELL;
        cur_row_m = 0;
        cur_col_m = 0;
        fg_m      = FG_RESET;
        bg_m      = BG_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        settle();
        test_directed();
        test_scroll();
        test_wrap();
        test_colors();
        test_backpressure();
        repeat (5)
        begin
            settle();
            write_reg(REG_FG_COLOR, CFG_DATA_W'($urandom_range(0, 15)));
            write_reg(REG_BG_COLOR, CFG_DATA_W'($urandom_range(0, 15)));
            test_random_text(PHASE_ITEMS);
        end

        settle();
        repeat (50) @(posedge clk);
        if (cell_cursor_q.size() != 0)
        begin
            $error("%0d output words never arrived", cell_cursor_q.size());
            fail_count++;
        end
        $display("covered %0d words: %0d reads, %0d newlines, %0d scrolls",
                 words_sent, reads_sent, newlines_sent, scroll_count);
        $display("with %0d register writes, including both color extremes",
                 reg_writes);
        if (fail_count == 0)
            $display("** text_console_writer: PASSED **");
        else
            $display("** text_console_writer: FAILED **");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d words pending", cell_cursor_q.size());
        $display("** text_console_writer: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
rtl/tcw_pkg.sv
rtl/tcw_screen_ram.sv
rtl/text_console_writer.sv
verif/tb.sv
